FILE: rtl/obpp_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box point penetration package
// Shared constants and width helpers for the box penetration pipeline.
// ----------------------------------------------------------------------------
package obpp_pkg;

  // Default coordinate width (Q8.8) and axis fraction bits (Q1.14).
  localparam int unsigned COORD_BITS_DEF     = 16;
  localparam int unsigned AXIS_FRAC_BITS_DEF = 14;

  // Number of points tested per query, one cell each.
  localparam int unsigned NUM_CORNERS = 4;

  // Width of the packed query word that travels down the cell row:
  // box x, box y, axis x, axis y, half length, half width, then the corners.
  function automatic int unsigned item_w(int unsigned cb, int unsigned af);
    return 2 * cb + 2 * (af + 2) + 2 * (cb - 1) + NUM_CORNERS * 2 * cb;
  endfunction

  // Width of the running result word: depth, push x, push y, contact x, contact y.
  function automatic int unsigned state_w(int unsigned cb);
    return (cb - 1) + 4 * cb;
  endfunction

endpackage

FILE: rtl/obpp_cell.sv
// ----------------------------------------------------------------------------
// Oriented box point penetration cell
// Tests one point of the query against the box and updates the running
// contact. Five register stages; the query word and the running result are
// handed to the next cell every cycle.
// ----------------------------------------------------------------------------
module obpp_cell #(
  parameter int unsigned COORD_BITS     = obpp_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_FRAC_BITS = obpp_pkg::AXIS_FRAC_BITS_DEF,
  parameter int unsigned IDX            = 0
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    valid_i,
  input  logic [obpp_pkg::item_w(COORD_BITS, AXIS_FRAC_BITS)-1:0] item_i,
  input  logic [obpp_pkg::state_w(COORD_BITS)-1:0]                state_i,
  output logic                                                    valid_o,
  output logic [obpp_pkg::item_w(COORD_BITS, AXIS_FRAC_BITS)-1:0] item_o,
  output logic [obpp_pkg::state_w(COORD_BITS)-1:0]                state_o
);
  import obpp_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned AF  = AXIS_FRAC_BITS;
  localparam int unsigned AW  = AF + 2;        // axis width
  localparam int unsigned HW  = CB - 1;        // extent width
  localparam int unsigned RW  = CB + 1;        // relative coordinate width
  localparam int unsigned PW  = RW + AW;       // projection product width
  localparam int unsigned SW  = PW + 1;        // projection sum width
  localparam int unsigned LW  = SW - AF;       // rounded projection width
  localparam int unsigned MW  = AW + 1;        // push multiplicand width
  localparam int unsigned QW  = MW + CB;       // push product width
  localparam int unsigned KW  = QW + 1 - AF;   // rounded push width
  localparam int unsigned IW  = item_w(CB, AF);
  localparam int unsigned STW = state_w(CB);
  localparam int unsigned NST = 5;

  // Field offsets inside the query word.
  localparam int unsigned OFS_BY  = CB;
  localparam int unsigned OFS_AX  = 2 * CB;
  localparam int unsigned OFS_AY  = OFS_AX + AW;
  localparam int unsigned OFS_HL  = OFS_AY + AW;
  localparam int unsigned OFS_HW  = OFS_HL + HW;
  localparam int unsigned OFS_PT  = OFS_HW + HW + IDX * 2 * CB;

  // Field offsets inside the running result word.
  localparam int unsigned OFS_PX = HW;
  localparam int unsigned OFS_PY = HW + CB;
  localparam int unsigned OFS_CX = HW + 2 * CB;
  localparam int unsigned OFS_CY = HW + 3 * CB;

  localparam logic signed [SW-1:0] PRJ_HALF = SW'(1) << (AF - 1);
  localparam logic signed [KW-1:0] SAT_HI   = {{(KW - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
  localparam logic signed [KW-1:0] SAT_LO   = {{(KW - CB + 1){1'b1}}, {(CB - 1){1'b0}}};

  // Delay lines for the query word, the running result and the valid flag.
  logic [IW-1:0]  item_q  [NST];
  logic [STW-1:0] state_q [NST-1];
  logic [NST-1:0] valid_q;

  // Stage one: point relative to the centre, four projection products.
  logic [CB-1:0]          pt_x, pt_y, box_x, box_y;
  logic signed [AW-1:0]   ax_in, ay_in;
  logic signed [RW-1:0]   rx, ry;
  logic signed [PW-1:0]   pa_d, pb_d, pc_d, pd_d, pa_q, pb_q, pc_q, pd_q;

  assign box_x = item_i[CB-1:0];
  assign box_y = item_i[OFS_BY +: CB];
  assign ax_in = item_i[OFS_AX +: AW];
  assign ay_in = item_i[OFS_AY +: AW];
  assign pt_x  = item_i[OFS_PT +: CB];
  assign pt_y  = item_i[OFS_PT + CB +: CB];

  always_comb begin
    rx   = $signed({pt_x[CB-1], pt_x}) - $signed({box_x[CB-1], box_x});
    ry   = $signed({pt_y[CB-1], pt_y}) - $signed({box_y[CB-1], box_y});
    pa_d = PW'(rx) * PW'(ax_in);
    pb_d = PW'(ry) * PW'(ay_in);
    pc_d = PW'(rx) * PW'(ay_in);
    pd_d = PW'(ry) * PW'(ax_in);
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;
    pb_q <= pb_d;
    pc_q <= pc_d;
    pd_q <= pd_d;
  end

  // Stage two: sum the products and round half up to Q8.8.
  logic signed [SW-1:0] sum_al, sum_ac;
  logic signed [LW-1:0] along_d, across_d, along_q, across_q;

  always_comb begin
    sum_al   = SW'(pa_q) + SW'(pb_q) + PRJ_HALF;
    sum_ac   = SW'(pc_q) - SW'(pd_q) + PRJ_HALF;
    along_d  = sum_al[SW-1:AF];
    across_d = sum_ac[SW-1:AF];
  end

  always_ff @(posedge clk_i) begin
    along_q  <= along_d;
    across_q <= across_d;
  end

  // Stage three: inside test, clearances and the push direction.
  logic [HW-1:0]          hl, hw;
  logic signed [AW-1:0]   ax_s3, ay_s3;
  logic signed [LW-1:0]   abs_al, abs_ac;
  logic [LW-2:0]          da, dc;
  logic [HW-1:0]          fa, fc;
  logic                   inside_d, use_al, pos_al, pos_ac;
  logic signed [CB-1:0]   s_d, s_q;
  logic signed [MW-1:0]   m1_d, m2_d, m1_q, m2_q;
  logic [HW-1:0]          fa_q, mn_q;
  logic                   inside_q;

  assign hl    = item_q[1][OFS_HL +: HW];
  assign hw    = item_q[1][OFS_HW +: HW];
  assign ax_s3 = item_q[1][OFS_AX +: AW];
  assign ay_s3 = item_q[1][OFS_AY +: AW];

  always_comb begin
    abs_al   = along_q[LW-1] ? -along_q : along_q;
    abs_ac   = across_q[LW-1] ? -across_q : across_q;
    da       = abs_al[LW-2:0];
    dc       = abs_ac[LW-2:0];
    inside_d = (da < (LW-1)'(hl)) && (dc < (LW-1)'(hw));
    fa       = hl - da[HW-1:0];
    fc       = hw - dc[HW-1:0];
    use_al   = fa < fc;
    pos_al   = !along_q[LW-1] && (along_q != '0);
    pos_ac   = !across_q[LW-1] && (across_q != '0);
    if (use_al) begin
      s_d  = pos_al ? $signed({1'b0, fa}) : -$signed({1'b0, fa});
      m1_d = $signed({ax_s3[AW-1], ax_s3});
      m2_d = $signed({ay_s3[AW-1], ay_s3});
    end else begin
      s_d  = pos_ac ? $signed({1'b0, fc}) : -$signed({1'b0, fc});
      m1_d = $signed({ay_s3[AW-1], ay_s3});
      m2_d = -$signed({ax_s3[AW-1], ax_s3});
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
    fa_q     <= fa;
    mn_q     <= use_al ? fa : fc;
    s_q      <= s_d;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
  end

  // Stage four: push products.
  logic signed [QW-1:0] q1_q, q2_q;
  logic [HW-1:0]        fa_s4_q, mn_s4_q;
  logic                 inside_s4_q;

  always_ff @(posedge clk_i) begin
    q1_q        <= QW'(m1_q) * QW'(s_q);
    q2_q        <= QW'(m2_q) * QW'(s_q);
    fa_s4_q     <= fa_q;
    mn_s4_q     <= mn_q;
    inside_s4_q <= inside_q;
  end

  // Stage five: round and saturate the push, then update the running result.
  logic signed [QW:0]   t1, t2;
  logic signed [KW-1:0] r1, r2;
  logic [CB-1:0]        push_x, push_y;
  logic [HW-1:0]        depth_in;
  logic                 take;
  logic [STW-1:0]       state_d, state_out_q;

  always_comb begin
    t1       = (QW+1)'(q1_q) + ((QW+1)'(1) << (AF - 1));
    t2       = (QW+1)'(q2_q) + ((QW+1)'(1) << (AF - 1));
    r1       = t1[QW:AF];
    r2       = t2[QW:AF];
    push_x   = (r1 > SAT_HI) ? SAT_HI[CB-1:0] : (r1 < SAT_LO) ? SAT_LO[CB-1:0] : r1[CB-1:0];
    push_y   = (r2 > SAT_HI) ? SAT_HI[CB-1:0] : (r2 < SAT_LO) ? SAT_LO[CB-1:0] : r2[CB-1:0];
    depth_in = state_q[NST-2][HW-1:0];
    take     = inside_s4_q && (mn_s4_q > depth_in);
    state_d  = state_q[NST-2];
    if (take) begin
      state_d[HW-1:0]       = fa_s4_q;
      state_d[OFS_PX +: CB] = push_x;
      state_d[OFS_PY +: CB] = push_y;
      state_d[OFS_CX +: CB] = item_q[3][OFS_PT +: CB];
      state_d[OFS_CY +: CB] = item_q[3][OFS_PT + CB +: CB];
    end
  end

  always_ff @(posedge clk_i) begin
    state_out_q <= state_d;
  end

  // Delay lines that keep the query word and running result aligned.
  always_ff @(posedge clk_i) begin
    item_q[0]  <= item_i;
    state_q[0] <= state_i;
    for (int k = 1; k < NST; k++) begin
      item_q[k] <= item_q[k-1];
    end
    for (int k = 1; k < NST - 1; k++) begin
      state_q[k] <= state_q[k-1];
    end
  end

  // Valid flags travel with the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NST-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[NST-1];
  assign item_o  = item_q[NST-1];
  assign state_o = state_out_q;

endmodule

FILE: rtl/oriented_box_point_penetration.sv
// ----------------------------------------------------------------------------
// Oriented box point penetration
// Five register stages in each of four cells lie between start and done_o.
// Throughput: one query word per cycle; busy is never raised, since the
// receiver cannot stall and nothing in the cell row is shared.
// Reset clears only the valid flags; no result strobes after reset until a
// new query word arrives.
// ----------------------------------------------------------------------------
module oriented_box_point_penetration #(
  parameter int unsigned COORD_BITS     = obpp_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_FRAC_BITS = obpp_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         box_x_i,
  input  logic [COORD_BITS-1:0]         box_y_i,
  input  logic [AXIS_FRAC_BITS+1:0]     axis_x_i,
  input  logic [AXIS_FRAC_BITS+1:0]     axis_y_i,
  input  logic [COORD_BITS-2:0]         half_len_i,
  input  logic [COORD_BITS-2:0]         half_wid_i,
  input  logic [2*COORD_BITS-1:0]       corner_a_i,
  input  logic [2*COORD_BITS-1:0]       corner_b_i,
  input  logic [2*COORD_BITS-1:0]       corner_c_i,
  input  logic [2*COORD_BITS-1:0]       corner_d_i,
  output logic                          done_o,
  output logic [COORD_BITS-2:0]         depth_o,
  output logic [COORD_BITS-1:0]         push_x_o,
  output logic [COORD_BITS-1:0]         push_y_o,
  output logic [COORD_BITS-1:0]         contact_x_o,
  output logic [COORD_BITS-1:0]         contact_y_o
);
  import obpp_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned HW  = CB - 1;
  localparam int unsigned IW  = item_w(COORD_BITS, AXIS_FRAC_BITS);
  localparam int unsigned STW = state_w(COORD_BITS);

  // Cell row links; entry zero feeds the first cell.
  logic [NUM_CORNERS:0]  valid_l;
  logic [IW-1:0]         item_l  [NUM_CORNERS+1];
  logic [STW-1:0]        state_l [NUM_CORNERS+1];

  // Pack the query word and seed the running result with the no-contact answer.
  assign valid_l[0] = start;
  assign item_l[0]  = {corner_d_i, corner_c_i, corner_b_i, corner_a_i,
                       half_wid_i, half_len_i, axis_y_i, axis_x_i, box_y_i, box_x_i};
  assign state_l[0] = {box_y_i, box_x_i, {(2*CB){1'b0}}, {HW{1'b0}}};

  // One cell per point, tested in order.
  for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_cell
    obpp_cell #(
      .COORD_BITS     (COORD_BITS),
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
      .IDX            (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_l[g]),
      .item_i  (item_l[g]),
      .state_i (state_l[g]),
      .valid_o (valid_l[g+1]),
      .item_o  (item_l[g+1]),
      .state_o (state_l[g+1])
    );
  end

  // Result word from the last cell.
  assign busy        = 1'b0;
  assign done_o      = valid_l[NUM_CORNERS];
  assign depth_o     = state_l[NUM_CORNERS][HW-1:0];
  assign push_x_o    = state_l[NUM_CORNERS][HW +: CB];
  assign push_y_o    = state_l[NUM_CORNERS][HW + CB +: CB];
  assign contact_x_o = state_l[NUM_CORNERS][HW + 2*CB +: CB];
  assign contact_y_o = state_l[NUM_CORNERS][HW + 3*CB +: CB];

  // The query word is carried for the cells but its tail is not needed here.
  logic unused_tail;
  assign unused_tail = ^item_l[NUM_CORNERS];

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Oriented box point penetration testbench
// Sends box and point queries in random bursts, predicts each result word
// from its own fixed-point model of the box test, and checks every strobed
// result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  import obpp_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int unsigned AF = AXIS_FRAC_BITS_DEF;
  localparam int unsigned CLK_HALF = 6;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned LATENCY = 20;
  localparam int unsigned RANDOM_QUERIES = 750;
  localparam longint LIMIT_CYCLES = 200000;

  // One query word, with a flag that makes the sender wait for an empty pipe.
  typedef struct packed {
    logic                      drain;
    logic [NUM_CORNERS-1:0][31:0] corner;
    logic [14:0]               half_wid;
    logic [14:0]               half_len;
    logic [15:0]               axis_y;
    logic [15:0]               axis_x;
    logic [15:0]               box_y;
    logic [15:0]               box_x;
  } query_t;

  // One result word.
  typedef struct packed {
    logic [14:0] depth;
    logic [15:0] push_x;
    logic [15:0] push_y;
    logic [15:0] contact_x;
    logic [15:0] contact_y;
  } contact_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] box_x_i = '0;
  logic [15:0] box_y_i = '0;
  logic [15:0] axis_x_i = '0;
  logic [15:0] axis_y_i = '0;
  logic [14:0] half_len_i = '0;
  logic [14:0] half_wid_i = '0;
  logic [31:0] corner_a_i = '0;
  logic [31:0] corner_b_i = '0;
  logic [31:0] corner_c_i = '0;
  logic [31:0] corner_d_i = '0;
  logic        done_o;
  logic [14:0] depth_o;
  logic [15:0] push_x_o;
  logic [15:0] push_y_o;
  logic [15:0] contact_x_o;
  logic [15:0] contact_y_o;

  query_t   pending_q[$];
  contact_t contact_q[$];
  query_t   cur_query = '0;
  logic     took = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       errors = 0;
  int       accepted = 0;
  int       checked = 0;
  int       hits = 0;
  int       saturated = 0;
  longint   cycle_count = 0;

  oriented_box_point_penetration #(
    .COORD_BITS    (CB),
    .AXIS_FRAC_BITS(AF)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .box_x_i    (box_x_i),
    .box_y_i    (box_y_i),
    .axis_x_i   (axis_x_i),
    .axis_y_i   (axis_y_i),
    .half_len_i (half_len_i),
    .half_wid_i (half_wid_i),
    .corner_a_i (corner_a_i),
    .corner_b_i (corner_b_i),
    .corner_c_i (corner_c_i),
    .corner_d_i (corner_d_i),
    .done_o     (done_o),
    .depth_o    (depth_o),
    .push_x_o   (push_x_o),
    .push_y_o   (push_y_o),
    .contact_x_o(contact_x_o),
    .contact_y_o(contact_y_o)
  );

  // Q.22 products back to Q8.8, rounding half up.
  function automatic longint round_q14(longint v);
    return (v + (64'sd1 <<< (AF - 1))) >>> AF;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Zero counts as negative when choosing the face to push toward.
  function automatic longint face_sign(longint v);
    return (v > 0) ? 64'sd1 : -64'sd1;
  endfunction

  // Expected contact for one query: points are tried in order, a point wins when its
  // minimum clearance exceeds the depth held so far, and the reported depth is the along clearance.
  function automatic contact_t penetration_of(query_t q);
    longint   bx, by, ax, ay, hl, hw, x, y, rx, ry;
    longint   along, across, da, dc, fa, fc, mn, s, deepest;
    contact_t r;
    int       k;
    bx = $signed(q.box_x);
    by = $signed(q.box_y);
    ax = $signed(q.axis_x);
    ay = $signed(q.axis_y);
    hl = q.half_len;
    hw = q.half_wid;
    deepest = 0;
    r = '0;
    r.contact_x = q.box_x;
    r.contact_y = q.box_y;
    for (k = 0; k < NUM_CORNERS; k++) begin
      x = $signed(q.corner[k][15:0]);
      y = $signed(q.corner[k][31:16]);
      rx = x - bx;
      ry = y - by;
      along = round_q14(rx * ax + ry * ay);
      across = round_q14(rx * ay - ry * ax);
      da = (along < 0) ? -along : along;
      dc = (across < 0) ? -across : across;
      if (da < hl && dc < hw) begin
        fa = hl - da;
        fc = hw - dc;
        mn = (fa < fc) ? fa : fc;
        if (mn > deepest) begin
          deepest = fa;
          r.depth = fa[14:0];
          r.contact_x = x[15:0];
          r.contact_y = y[15:0];
          if (fa < fc) begin
            s = face_sign(along) * fa;
            r.push_x = clamp16(round_q14(ax * s));
            r.push_y = clamp16(round_q14(ay * s));
          end else begin
            s = face_sign(across) * fc;
            r.push_x = clamp16(round_q14(ay * s));
            r.push_y = clamp16(round_q14(-ax * s));
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pt(int x, int y);
    return {y[15:0], x[15:0]};
  endfunction

  function automatic query_t make_query(int bx, int by, int ax, int ay, int hl, int hw,
                                        logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                        logic [31:0] d, logic drain);
    query_t q;
    q.box_x = bx[15:0];
    q.box_y = by[15:0];
    q.axis_x = ax[15:0];
    q.axis_y = ay[15:0];
    q.half_len = hl[14:0];
    q.half_wid = hw[14:0];
    q.corner[0] = a;
    q.corner[1] = b;
    q.corner[2] = c;
    q.corner[3] = d;
    q.drain = drain;
    return q;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // Clock.
  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Reset, released on a falling edge.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: bursts of query words separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !took) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0 && pending_q[0].drain && contact_q.size() != 0) begin
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_query  <= pending_q[0];
        box_x_i    <= pending_q[0].box_x;
        box_y_i    <= pending_q[0].box_y;
        axis_x_i   <= pending_q[0].axis_x;
        axis_y_i   <= pending_q[0].axis_y;
        half_len_i <= pending_q[0].half_len;
        half_wid_i <= pending_q[0].half_wid;
        corner_a_i <= pending_q[0].corner[0];
        corner_b_i <= pending_q[0].corner[1];
        corner_c_i <= pending_q[0].corner[2];
        corner_d_i <= pending_q[0].corner[3];
        void'(pending_q.pop_front());
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Acceptance, result checking and the cycle limit.
  always @(posedge clk_i) begin
    contact_t want;
    cycle_count++;
    took <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (start && !busy) begin
        contact_q.push_back(penetration_of(cur_query));
        accepted++;
      end
      if (done_o) begin
        if (contact_q.size() == 0) begin
          report_mismatch("result word with no query outstanding");
        end else begin
          want = contact_q.pop_front();
          checked++;
          if (want.depth != 0) hits++;
          if (want.push_x == 16'h7fff || want.push_x == 16'h8000 ||
              want.push_y == 16'h7fff || want.push_y == 16'h8000) saturated++;
          if (depth_o !== want.depth)
            report_mismatch($sformatf("depth got %h want %h", depth_o, want.depth));
          if (push_x_o !== want.push_x)
            report_mismatch($sformatf("push_x got %h want %h", push_x_o, want.push_x));
          if (push_y_o !== want.push_y)
            report_mismatch($sformatf("push_y got %h want %h", push_y_o, want.push_y));
          if (contact_x_o !== want.contact_x)
            report_mismatch($sformatf("contact_x got %h want %h", contact_x_o,
                                      want.contact_x));
          if (contact_y_o !== want.contact_y)
            report_mismatch($sformatf("contact_y got %h want %h", contact_y_o,
                                      want.contact_y));
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ERROR: run exceeded %0d cycles", LIMIT_CYCLES);
      $display("oriented_box_point_penetration test failed");
      $finish;
    end
  end

  // Stimulus and end of test.
  initial begin
    real    theta;
    int     ax, ay, bx, by, hl, hw, span, i, k;
    logic [31:0] c[4];
    query_t q;

    // Directed queries: empty box, face selection, ties, boundaries,
    // saturation, degenerate axes and coordinate extremes.
    pending_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h400, 'h400, pt(0, 0),
                        pt(32767, 32767), pt(32767, 32767), pt(32767, 32767), 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h100, 'h800, pt('h80, 0),
                        pt(-'h7000, 0), 0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h100, 'h800, pt(-'h80, 0),
                        0, 0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h800, 'h100, pt(0, 'h20),
                        0, 0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h800, 'h100, pt(0, -'h20),
                        pt(0, -'h30), 0, 0, 1'b0));
    pending_q.push_back(make_query('h100, -'h100, 16384, 0, 'h400, 'h400, pt('h140, -'h100),
                        pt('hc0, -'h100), pt('h100, -'hc0), pt('h100, -'h140), 1'b1));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h400, 'h400, pt('h300, 0),
                        pt('h200, 0), pt('h100, 0), pt(0, 0), 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h100, 'h100, pt('h100, 0),
                        pt(0, 'h100), pt('hff, 0), pt(-'h100, 0), 1'b0));
    pending_q.push_back(make_query(0, 0, 'h7fff, 'h7fff, 'h7fff, 'h7fff, pt(0, 0),
                        0, 0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, -32768, -32768, 'h7fff, 'h7fff, pt(0, 0),
                        pt(1, 1), 0, 0, 1'b0));
    pending_q.push_back(make_query('h40, 'h40, 8000, 3000, 'h600, 'h300, pt('h100, 'h80),
                        pt(-'h200, 'h40), pt('h40, 'h40), pt('h300, -'h100), 1'b0));
    pending_q.push_back(make_query(32767, 32767, 0, 16384, 'h7fff, 'h7fff,
                        pt(-32768, -32768), pt(32767, 'h7ff0), pt(0, 0),
                        pt(32767, 32767), 1'b0));
    pending_q.push_back(make_query(-32768, -32768, 0, -16384, 'h7fff, 'h7fff,
                        pt(32767, 32767), pt(-32768, -32768), pt(-'h7f00, -'h7f00),
                        pt(0, 0), 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h7fff, 0, pt(0, 0), pt(1, 0),
                        0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 0, 'h7fff, pt(0, 0), pt(0, 1),
                        0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, 0, 0, 'h100, 'h100, pt('h50, 'h50), pt(0, 0),
                        0, 0, 1'b0));
    pending_q.push_back(make_query(0, 0, 11585, 11585, 'h500, 'h200, pt('h100, 'h100),
                        pt('h300, 'h200), pt(-'h100, 'h80), pt('h80, -'h80), 1'b0));
    pending_q.push_back(make_query('hffff, 'hffff, 'hffff, 'hffff, 'h7fff, 'h7fff,
                        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0));
    pending_q.push_back(make_query(0, 0, 16384, 0, 'h200, 'h200, pt(0, 0), pt(0, 0),
                        pt(0, 0), pt(0, 0), 1'b0));
    pending_q.push_back(make_query(0, 0, -16384, 0, 'h200, 'h300, pt('h10, 'h10),
                        pt(-'h10, -'h10), pt('h1f0, 0), pt(0, 'h2f0), 1'b0));

    // Random queries: mostly unit-axis boxes with points scattered around
    // them, the rest raw words on every field.
    for (i = 0; i < RANDOM_QUERIES; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        theta = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
        ax = $rtoi($floor(16384.0 * $cos(theta) + 0.5));
        ay = $rtoi($floor(16384.0 * $sin(theta) + 0.5));
        bx = $urandom_range(0, 32767) - 16384;
        by = $urandom_range(0, 32767) - 16384;
        hl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(16, 4096);
        hw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(16, 4096);
        span = ((hl > hw) ? hl : hw) + 64;
        for (k = 0; k < NUM_CORNERS; k++) begin
          c[k] = pt(bx + $urandom_range(0, 2 * span) - span,
                    by + $urandom_range(0, 2 * span) - span);
        end
        q = make_query(bx, by, ax, ay, hl, hw, c[0], c[1], c[2], c[3], 1'b0);
      end else begin
        q = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, 1'b0);
      end
      q.drain = (i == RANDOM_QUERIES / 3) || (i == 2 * RANDOM_QUERIES / 3);
      pending_q.push_back(q);
    end

    // Wait for every word to be taken and every result to return.
    while (pending_q.size() != 0 || start || contact_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (contact_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", contact_q.size()));

    $display("Covered %0d queries, %0d results checked: %0d with a contact point,",
             accepted, checked, hits);
    $display("%0d with a saturated push, %0d errors.", saturated, errors);
    if (errors == 0) begin
      $display("oriented_box_point_penetration test passed");
    end else begin
      $display("oriented_box_point_penetration test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/obpp_pkg.sv
rtl/obpp_cell.sv
rtl/oriented_box_point_penetration.sv
dv/tb.sv
